// ----- rtl/lfrr_pkg.sv -----
// Shared types and constants for the line-framed receive ring.
`timescale 1ns / 1ps
`default_nettype none
package lfrr_pkg;

    localparam int DEF_RING_DEPTH = 256;
    localparam int DEF_LINE_LEN   = 64;
    localparam int BYTE_W         = 8;
    localparam int FRAMES_W       = 9;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic push;
        logic pop;
        logic frm_inc;
        logic frm_dec;
    } t_ring_cmd;

endpackage
`default_nettype wire

// ----- rtl/lfrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lfrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfrr_ptrs.sv -----
// Ring bookkeeping: write/read pointers, fill count and complete-frame count.
`timescale 1ns / 1ps
`default_nettype none
module lfrr_ptrs
    import lfrr_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire t_ring_cmd                  i_cmd,
    output logic [$clog2(RING_DEPTH)-1:0]   o_wr_ptr,
    output logic [$clog2(RING_DEPTH)-1:0]   o_rd_ptr,
    output logic [$clog2(RING_DEPTH+1)-1:0] o_fill,
    output logic [FRAMES_W-1:0]             o_frames
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FRAMES_W-1:0] r_frames, n_frames;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        n_frames = r_frames;
        if (i_cmd.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_cmd.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_cmd.push && !i_cmd.pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_fill = r_fill - FILL_W'(1);
        end
        if (i_cmd.frm_inc && !i_cmd.frm_dec) begin
            n_frames = r_frames + FRAMES_W'(1);
        end else if (i_cmd.frm_dec && !i_cmd.frm_inc) begin
            n_frames = r_frames - FRAMES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_frames <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
            r_frames <= n_frames;
        end
    end

    assign o_wr_ptr = r_wr_ptr;
    assign o_rd_ptr = r_rd_ptr;
    assign o_fill   = r_fill;
    assign o_frames = r_frames;

endmodule
`default_nettype wire

// ----- rtl/line_framed_receive_ring.sv -----
// A received byte's status transfer is registered: it is shown in the cycle
// after acceptance. Frame requests read each ring byte (S_FETCH), compare it
// (S_EXAM) and wait on output stalls; each kept character is its own transfer.
// Throughput: one item at a time; input stalls while draining or a result waits.
// Reset: synchronous active low; clears pointers, counts and sequencer.
// Ring contents are not cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module line_framed_receive_ring
    import lfrr_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int LINE_LEN   = DEF_LINE_LEN
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_op,
    input  wire  [BYTE_W-1:0]   i_rx_byte,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [BYTE_W-1:0]   o_frame_char,
    output logic                o_char_valid,
    output logic                o_frame_ok,
    output logic                o_dropped,
    output logic [FRAMES_W-1:0] o_frames_waiting,
    output logic                o_last
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int KEPT_W = $clog2(LINE_LEN);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
    localparam logic [KEPT_W-1:0] KEPT_MAX  = KEPT_W'(LINE_LEN - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXAM  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [KEPT_W-1:0]   r_kept, n_kept;
    logic [BYTE_W-1:0]   r_hold, n_hold;
    logic                r_ov, n_ov;
    logic [BYTE_W-1:0]   r_char, n_char;
    logic                r_cv, n_cv;
    logic                r_ok, n_ok;
    logic                r_drop, n_drop;
    logic [FRAMES_W-1:0] r_fw, n_fw;
    logic                r_last, n_last;

    t_ring_cmd           ring_cmd;
    logic [PTR_W-1:0]    wr_ptr, rd_ptr;
    logic [FILL_W-1:0]   fill;
    logic [FRAMES_W-1:0] frames;
    logic                ram_we, ram_re;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                in_acc, out_free, full;

    lfrr_ptrs #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ptrs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .o_wr_ptr(wr_ptr),
        .o_rd_ptr(rd_ptr),
        .o_fill  (fill),
        .o_frames(frames)
    );

    lfrr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(wr_ptr),
        .i_wdata(i_rx_byte),
        .i_re   (ram_re),
        .i_raddr(rd_ptr),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE) || r_ov;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign full       = (fill == FILL_FULL);

    always_comb begin
        n_state  = r_state;
        n_kept   = r_kept;
        n_hold   = r_hold;
        n_ov     = r_ov && i_out_stall;
        n_char   = r_char;
        n_cv     = r_cv;
        n_ok     = r_ok;
        n_drop   = r_drop;
        n_fw     = r_fw;
        n_last   = r_last;
        ring_cmd = '0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_op) begin
                        n_ov   = 1'b1;
                        n_char = '0;
                        n_cv   = 1'b0;
                        n_ok   = 1'b0;
                        n_drop = full;
                        n_last = 1'b1;
                        n_fw   = frames;
                        if (!full) begin
                            ram_we        = 1'b1;
                            ring_cmd.push = 1'b1;
                            if (i_rx_byte == CH_LF) begin
                                ring_cmd.frm_inc = 1'b1;
                                n_fw             = frames + FRAMES_W'(1);
                            end
                        end
                    end else if (frames == '0) begin
                        n_ov   = 1'b1;
                        n_char = '0;
                        n_cv   = 1'b0;
                        n_ok   = 1'b0;
                        n_drop = 1'b0;
                        n_last = 1'b1;
                        n_fw   = frames;
                    end else begin
                        n_kept  = '0;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                ram_re  = 1'b1;
                n_state = S_EXAM;
            end
            S_EXAM: begin
                if (ram_rdata == CH_LF) begin
                    if (r_kept == '0) begin
                        // empty frame: skip it, or report none if it was the last
                        ring_cmd.pop     = 1'b1;
                        ring_cmd.frm_dec = 1'b1;
                        if (frames == FRAMES_W'(1)) begin
                            n_ov    = 1'b1;
                            n_char  = '0;
                            n_cv    = 1'b0;
                            n_ok    = 1'b0;
                            n_drop  = 1'b0;
                            n_last  = 1'b1;
                            n_fw    = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end else if (out_free) begin
                        ring_cmd.pop     = 1'b1;
                        ring_cmd.frm_dec = 1'b1;
                        n_ov    = 1'b1;
                        n_char  = r_hold;
                        n_cv    = 1'b1;
                        n_ok    = 1'b1;
                        n_drop  = 1'b0;
                        n_last  = 1'b1;
                        n_fw    = frames - FRAMES_W'(1);
                        n_state = S_IDLE;
                    end
                end else if (ram_rdata == CH_CR || r_kept == KEPT_MAX) begin
                    ring_cmd.pop = 1'b1;
                    n_state      = S_FETCH;
                end else if (r_kept == '0) begin
                    ring_cmd.pop = 1'b1;
                    n_hold       = ram_rdata;
                    n_kept       = KEPT_W'(1);
                    n_state      = S_FETCH;
                end else if (out_free) begin
                    // one character held back so the final one can carry last
                    ring_cmd.pop = 1'b1;
                    n_ov    = 1'b1;
                    n_char  = r_hold;
                    n_cv    = 1'b1;
                    n_ok    = 1'b1;
                    n_drop  = 1'b0;
                    n_last  = 1'b0;
                    n_fw    = frames - FRAMES_W'(1);
                    n_hold  = ram_rdata;
                    n_kept  = r_kept + KEPT_W'(1);
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept <= n_kept;
        r_hold <= n_hold;
        r_char <= n_char;
        r_cv   <= n_cv;
        r_ok   <= n_ok;
        r_drop <= n_drop;
        r_fw   <= n_fw;
        r_last <= n_last;
    end

    assign o_out_valid      = r_ov;
    assign o_frame_char     = r_char;
    assign o_char_valid     = r_cv;
    assign o_frame_ok       = r_ok;
    assign o_dropped        = r_drop;
    assign o_frames_waiting = r_fw;
    assign o_last           = r_last;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= FILL_FULL)
        else $error("ring fill count above depth");

    a_frames_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, frames} <= 10'(fill))
        else $error("more frames than stored bytes");

    a_fetch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (fill != '0) && (frames != '0))
        else $error("drain reads an empty ring");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_op) |=> (o_out_valid && o_last && !o_char_valid))
        else $error("received byte gave no status transfer");

endmodule
`default_nettype wire
